[sv/ucdw_pkg.sv]
`default_nettype none

package ucdw_pkg;

  // Input item kind
  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_NEXT  = 2'd1,
    KIND_GONE  = 2'd2
  } kind_e;

  // Claimed interface class as shown on the result
  typedef enum logic [1:0] {
    CLAIM_NONE = 2'd0,
    CLAIM_MIDI = 2'd1,
    CLAIM_KBD  = 2'd2
  } claim_e;

  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;

  localparam logic [7:0] CLASS_AUDIO    = 8'h01;
  localparam logic [7:0] SUBCLASS_MIDI  = 8'h03;
  localparam logic [7:0] PROTO_NONE     = 8'h00;
  localparam logic [7:0] CLASS_HID      = 8'h03;
  localparam logic [7:0] SUBCLASS_BOOT  = 8'h01;
  localparam logic [7:0] PROTO_KEYBOARD = 8'h01;

  localparam logic [1:0] XFER_BULK = 2'd2;
  localparam logic [1:0] XFER_INTR = 2'd3;

  // One completed descriptor, handed from the walker to the claim logic
  typedef struct packed {
    logic       fire;
    logic [7:0] dtype;
    logic [7:0] field2;
    logic [7:0] field3;
    logic [7:0] field4;
    logic [7:0] field5;
    logic [7:0] field6;
    logic [7:0] field7;
  } desc_evt_t;

endpackage

`default_nettype wire

[sv/usb_config_descriptor_walker.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// input    | in_valid_i / in_ready_o | kind_i, desc_byte_i
// result   | out_valid_o/out_ready_i | claimed_class_o .. walk_done_o (one per input)
//
// One input transfer every cycle while the result slot is free or being taken.
// The input register feeds the walk and claim logic; the walk and claim
// registers themselves form the result register, so they advance only when the
// result slot is free or being taken.
// A stalled result holds the state; one further input transfer waits in the input register.
// Reset clears the walk, the claim and both valid flags.
`default_nettype none

module usb_config_descriptor_walker #(
  parameter int unsigned CAPTURE_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  desc_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  claimed_class_o,
  output logic [7:0]  claimed_interface_o,
  output logic        keyboard_ready_o,
  output logic        midi_ready_o,
  output logic [7:0]  in_endpoint_o,
  output logic [7:0]  out_endpoint_o,
  output logic [7:0]  poll_interval_o,
  output logic [15:0] max_packet_o,
  output logic        parse_error_o,
  output logic        walk_done_o
);

  logic       s1_valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       advance, step, gone;

  ucdw_pkg::desc_evt_t evt;
  ucdw_pkg::claim_e    claim;

  // Advance when the result slot is empty or its transfer completes this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign gone       = step && (kind_q == ucdw_pkg::KIND_GONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      byte_q <= desc_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Split bytes into descriptors, track total length, error and done
  ucdw_walker #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (kind_q),
    .byte_i (byte_q),
    .evt_o  (evt),
    .error_o(parse_error_o),
    .done_o (walk_done_o)
  );

  // Claim the interface and collect its endpoints from completed descriptors
  ucdw_claim u_claim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gone_i    (gone),
    .evt_i     (evt),
    .claim_o   (claim),
    .iface_o   (claimed_interface_o),
    .kbd_rdy_o (keyboard_ready_o),
    .midi_rdy_o(midi_ready_o),
    .ep_in_o   (in_endpoint_o),
    .ep_out_o  (out_endpoint_o),
    .interval_o(poll_interval_o),
    .mps_o     (max_packet_o)
  );

  assign claimed_class_o = claim;
  assign out_valid_o     = out_valid_q;

  // An error always stops the walk
  a_error_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_error_o |-> walk_done_o)
    else $error("parse error without walk done");

  a_midi_claim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    midi_ready_o |-> (claim == ucdw_pkg::CLAIM_MIDI))
    else $error("midi ready without midi claim");

  a_kbd_claim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyboard_ready_o |-> (claim == ucdw_pkg::CLAIM_KBD))
    else $error("keyboard ready without keyboard claim");

  // State moves only on a step, so a stalled result holds its walk flags
  a_hold_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(walk_done_o) && $stable(claim))
    else $error("result state changed under stall");

endmodule

`default_nettype wire

[sv/ucdw_walker.sv]
`default_nettype none

module ucdw_walker #(
  parameter int unsigned CAPTURE_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          byte_i,
  output ucdw_pkg::desc_evt_t evt_o,
  output logic                error_o,
  output logic                done_o
);

  logic [15:0] off_q, off_d, off_b, off_n;
  logic [15:0] tot_q, tot_d, tot_b, tot_new;
  logic [7:0]  len_q, len_d, len_b, len_n;
  logic [7:0]  pos_q, pos_d, pos_b;
  logic [7:0]  type_q, type_d, type_b, type_n;
  logic [7:0]  cap_q [CAPTURE_BYTES];
  logic [7:0]  cap_d [CAPTURE_BYTES];
  logic [7:0]  cap_n [CAPTURE_BYTES];
  logic        err_q, err_d, err_b;
  logic        done_q, done_d, done_b;

  logic        is_first, is_byte, feed;
  logic        at_start, zero_len, overrun, early_err;
  logic [16:0] off_sum;
  logic        hdr, more, hdr_err;

  always_comb begin
    is_first = (kind_i == ucdw_pkg::KIND_FIRST);
    is_byte  = is_first || (kind_i == ucdw_pkg::KIND_NEXT);

    // A new set restarts the walk
    off_b  = is_first ? 16'd0 : off_q;
    tot_b  = is_first ? 16'd0 : tot_q;
    len_b  = is_first ? 8'd0  : len_q;
    pos_b  = is_first ? 8'd0  : pos_q;
    type_b = is_first ? 8'd0  : type_q;
    err_b  = is_first ? 1'b0  : err_q;
    done_b = is_first ? 1'b0  : done_q;

    feed      = is_byte && !done_b;
    at_start  = (pos_b == 8'd0);
    zero_len  = at_start && (byte_i == 8'd0);
    off_sum   = {1'b0, off_b} + {9'd0, byte_i};
    overrun   = at_start && (off_b != 16'd0) && (off_sum > {1'b0, tot_b});
    early_err = zero_len || overrun;

    len_n  = at_start ? byte_i : len_b;
    type_n = (pos_b == 8'd1) ? byte_i : (at_start ? 8'd0 : type_b);
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      cap_n[i] = (pos_b == 8'(i)) ? byte_i : (at_start ? 8'd0 : cap_q[i]);
    end

    hdr     = (off_b == {8'd0, pos_b});
    off_n   = off_b + 16'd1;
    more    = ({1'b0, pos_b} + 9'd1) < {1'b0, len_n};
    tot_new = hdr ? {cap_n[3], cap_n[2]} : tot_b;
    hdr_err = hdr && ({8'd0, len_n} > tot_new);

    // Hold everything but the restart by default
    off_d  = off_b;
    tot_d  = tot_b;
    len_d  = len_b;
    pos_d  = pos_b;
    type_d = type_b;
    err_d  = err_b;
    done_d = done_b;
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      cap_d[i] = is_first ? 8'd0 : cap_q[i];
    end

    if (feed) begin
      if (early_err) begin
        err_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        off_d  = off_n;
        len_d  = len_n;
        type_d = type_n;
        cap_d  = cap_n;
        pos_d  = more ? pos_b + 8'd1 : 8'd0;
        if (!more) begin
          tot_d = tot_new;
          if (hdr_err) begin
            err_d  = 1'b1;
            done_d = 1'b1;
          end else if (off_n >= tot_new) begin
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    evt_o.fire   = step_i && feed && !early_err && !more && !hdr_err;
    evt_o.dtype  = type_n;
    evt_o.field2 = cap_n[2];
    evt_o.field3 = cap_n[3];
    evt_o.field4 = cap_n[4];
    evt_o.field5 = cap_n[5];
    evt_o.field6 = cap_n[6];
    evt_o.field7 = cap_n[7];
  end

  assign error_o = err_q;
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      tot_q  <= '0;
      len_q  <= '0;
      pos_q  <= '0;
      type_q <= '0;
      err_q  <= 1'b0;
      done_q <= 1'b0;
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        cap_q[i] <= '0;
      end
    end else if (step_i) begin
      off_q  <= off_d;
      tot_q  <= tot_d;
      len_q  <= len_d;
      pos_q  <= pos_d;
      type_q <= type_d;
      err_q  <= err_d;
      done_q <= done_d;
      cap_q  <= cap_d;
    end
  end

endmodule

`default_nettype wire

[sv/ucdw_claim.sv]
`default_nettype none

module ucdw_claim (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                gone_i,
  input  ucdw_pkg::desc_evt_t evt_i,
  output ucdw_pkg::claim_e    claim_o,
  output logic [7:0]          iface_o,
  output logic                kbd_rdy_o,
  output logic                midi_rdy_o,
  output logic [7:0]          ep_in_o,
  output logic [7:0]          ep_out_o,
  output logic [7:0]          interval_o,
  output logic [15:0]         mps_o
);

  ucdw_pkg::claim_e claim_q, claim_d;
  logic [7:0]  iface_q, iface_d;
  logic        kbd_rdy_q, kbd_rdy_d;
  logic        midi_in_q, midi_in_d;
  logic        midi_out_q, midi_out_d;
  logic        midi_rdy_q, midi_rdy_d;
  logic [7:0]  ep_in_q, ep_in_d;
  logic [7:0]  ep_out_q, ep_out_d;
  logic [7:0]  interval_q, interval_d;
  logic [15:0] mps_q, mps_d;

  logic        is_midi, is_kbd, dir_in;
  logic [1:0]  xfer;

  always_comb begin
    is_midi = (evt_i.field5 == ucdw_pkg::CLASS_AUDIO) &&
              (evt_i.field6 == ucdw_pkg::SUBCLASS_MIDI) &&
              (evt_i.field7 == ucdw_pkg::PROTO_NONE);
    is_kbd  = (evt_i.field5 == ucdw_pkg::CLASS_HID) &&
              (evt_i.field6 == ucdw_pkg::SUBCLASS_BOOT) &&
              (evt_i.field7 == ucdw_pkg::PROTO_KEYBOARD);
    xfer    = evt_i.field3[1:0];
    dir_in  = evt_i.field2[7];

    claim_d    = claim_q;
    iface_d    = iface_q;
    kbd_rdy_d  = kbd_rdy_q;
    midi_in_d  = midi_in_q;
    midi_out_d = midi_out_q;
    midi_rdy_d = midi_rdy_q;
    ep_in_d    = ep_in_q;
    ep_out_d   = ep_out_q;
    interval_d = interval_q;
    mps_d      = mps_q;

    if (gone_i) begin
      claim_d    = ucdw_pkg::CLAIM_NONE;
      iface_d    = '0;
      kbd_rdy_d  = 1'b0;
      midi_in_d  = 1'b0;
      midi_out_d = 1'b0;
      midi_rdy_d = 1'b0;
      ep_in_d    = '0;
      ep_out_d   = '0;
      interval_d = '0;
      mps_d      = '0;
    end else if (evt_i.fire) begin
      if (evt_i.dtype == ucdw_pkg::DESC_INTERFACE) begin
        if (claim_q == ucdw_pkg::CLAIM_NONE) begin
          if (is_midi) begin
            claim_d = ucdw_pkg::CLAIM_MIDI;
            iface_d = evt_i.field2;
          end else if (is_kbd) begin
            claim_d = ucdw_pkg::CLAIM_KBD;
            iface_d = evt_i.field2;
          end
        end
      end else if (evt_i.dtype == ucdw_pkg::DESC_ENDPOINT) begin
        if (claim_q == ucdw_pkg::CLAIM_KBD && !kbd_rdy_q) begin
          if (xfer == ucdw_pkg::XFER_INTR && dir_in) begin
            ep_in_d    = evt_i.field2;
            interval_d = evt_i.field6;
            mps_d      = {evt_i.field5, evt_i.field4};
            kbd_rdy_d  = 1'b1;
          end
        end else if (claim_q == ucdw_pkg::CLAIM_MIDI && !midi_rdy_q &&
                     xfer == ucdw_pkg::XFER_BULK) begin
          if (dir_in) begin
            ep_in_d   = evt_i.field2;
            midi_in_d = 1'b1;
          end else begin
            ep_out_d   = evt_i.field2;
            midi_out_d = 1'b1;
          end
          mps_d      = {evt_i.field5, evt_i.field4};
          midi_rdy_d = midi_in_d && midi_out_d;
        end
      end
    end
  end

  assign claim_o    = claim_q;
  assign iface_o    = iface_q;
  assign kbd_rdy_o  = kbd_rdy_q;
  assign midi_rdy_o = midi_rdy_q;
  assign ep_in_o    = ep_in_q;
  assign ep_out_o   = ep_out_q;
  assign interval_o = interval_q;
  assign mps_o      = mps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      claim_q    <= ucdw_pkg::CLAIM_NONE;
      iface_q    <= '0;
      kbd_rdy_q  <= 1'b0;
      midi_in_q  <= 1'b0;
      midi_out_q <= 1'b0;
      midi_rdy_q <= 1'b0;
      ep_in_q    <= '0;
      ep_out_q   <= '0;
      interval_q <= '0;
      mps_q      <= '0;
    end else begin
      claim_q    <= claim_d;
      iface_q    <= iface_d;
      kbd_rdy_q  <= kbd_rdy_d;
      midi_in_q  <= midi_in_d;
      midi_out_q <= midi_out_d;
      midi_rdy_q <= midi_rdy_d;
      ep_in_q    <= ep_in_d;
      ep_out_q   <= ep_out_d;
      interval_q <= interval_d;
      mps_q      <= mps_d;
    end
  end

endmodule

`default_nettype wire
